>>> rtl/htm_pkg.sv
package htm_pkg;

    localparam int HR_W = 16;
    localparam logic [HR_W-1:0] FX_ONE = 16'd1024;
    localparam logic [HR_W-1:0] HEADROOM_RESET = 16'd1024;

endpackage

>>> rtl/htm_pixel_if.sv
interface htm_pixel_if #(
    parameter int CHANNEL_WIDTH = 16
);
    logic                     valid;
    logic                     ready;
    logic [CHANNEL_WIDTH-1:0] red_in;
    logic [CHANNEL_WIDTH-1:0] green_in;
    logic [CHANNEL_WIDTH-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

>>> rtl/htm_result_if.sv
interface htm_result_if #(
    parameter int CHANNEL_WIDTH = 16
);
    logic                     valid;
    logic                     ready;
    logic [CHANNEL_WIDTH-1:0] red_out;
    logic [CHANNEL_WIDTH-1:0] green_out;
    logic [CHANNEL_WIDTH-1:0] blue_out;
    logic                     compressed;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output compressed, input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  input compressed, output ready);
endinterface

>>> rtl/hdr_highlight_tone_map.sv
// Highlight compression for HDR output: one RGB pixel (unsigned Q6.10) in and one
// out per clock unless the output stalls. A pixel whose peak channel exceeds 1.0
// has its peak mapped by a Reinhard curve toward the headroom register and all
// channels scaled with it; compressed flags such pixels. The pipeline holds two
// bit-per-stage restoring dividers: 16 stages for the curve quotient and
// CHANNEL_WIDTH stages for the per-channel scale. A stalled output freezes the
// whole pipeline. Write headroom only while the pipeline is empty.
module hdr_highlight_tone_map #(
    parameter int CHANNEL_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      headroom_we,
    input  logic [htm_pkg::HR_W-1:0]  headroom_data,
    htm_pixel_if.sink                 pixel,
    htm_result_if.source              result
);

    localparam int W   = CHANNEL_WIDTH;
    localparam int HW  = htm_pkg::HR_W;
    localparam int PW  = W + HW;
    localparam int DW  = ((W > HW) ? W : HW) + 1;
    localparam int C1W = PW + DW;
    localparam int C2W = PW + W;

    logic [HW-1:0] headroom_reg;
    logic          adv;
    logic          out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            headroom_reg <= htm_pkg::HEADROOM_RESET;
        end
        else if (headroom_we)
        begin
            headroom_reg <= headroom_data;
        end
    end

    // hold every stage while the output waits
    assign adv = !(out_valid_reg && !result.ready);
    assign pixel.ready = adv;

    // stage 1: capture and peak
    logic         v1_reg;
    logic [W-1:0] r1_reg, g1_reg, b1_reg, m1_reg;
    logic [W-1:0] m_rg;

    assign m_rg = (pixel.green_in > pixel.red_in) ? pixel.green_in : pixel.red_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg <= pixel.red_in;
            g1_reg <= pixel.green_in;
            b1_reg <= pixel.blue_in;
            m1_reg <= (pixel.blue_in > m_rg) ? pixel.blue_in : m_rg;
        end
    end

    // stage 2: span, excess over white, curve numerator and denominator
    logic [W:0]    m1_ext;
    logic          big1;
    logic [W-1:0]  over1;
    logic [HW-1:0] span1;

    assign m1_ext = {1'b0, m1_reg};
    assign big1   = m1_ext > (W+1)'(htm_pkg::FX_ONE);
    assign over1  = W'(m1_ext - (W+1)'(htm_pkg::FX_ONE));
    assign span1  = headroom_reg - htm_pkg::FX_ONE;

    logic          dv1_v   [0:HW];
    logic [PW-1:0] dv1_rem [0:HW];
    logic [DW-1:0] dv1_div [0:HW];
    logic [HW-1:0] dv1_q   [0:HW];
    logic [W-1:0]  dv1_r   [0:HW];
    logic [W-1:0]  dv1_g   [0:HW];
    logic [W-1:0]  dv1_b   [0:HW];
    logic [W-1:0]  dv1_m   [0:HW];
    logic          dv1_big [0:HW];
    logic          dv1_hr  [0:HW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv1_v[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv1_v[0] <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv1_rem[0] <= PW'(span1) * PW'(over1);
            dv1_div[0] <= DW'(span1) + DW'(over1);
            dv1_q[0]   <= '0;
            dv1_r[0]   <= r1_reg;
            dv1_g[0]   <= g1_reg;
            dv1_b[0]   <= b1_reg;
            dv1_m[0]   <= m1_reg;
            dv1_big[0] <= big1;
            dv1_hr[0]  <= headroom_reg > htm_pkg::FX_ONE;
        end
    end

    // curve quotient, one bit per stage, MSB first
    for (genvar k = 0; k < HW; k++)
    begin : g_div1
        logic [C1W-1:0] trial;
        logic           fits;

        assign trial = C1W'(dv1_div[k]) << (HW - 1 - k);
        assign fits  = C1W'(dv1_rem[k]) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv1_v[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv1_v[k+1] <= dv1_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv1_rem[k+1] <= fits ? PW'(C1W'(dv1_rem[k]) - trial) : dv1_rem[k];
                dv1_q[k+1]   <= dv1_q[k] | (fits ? (HW'(1) << (HW - 1 - k)) : '0);
                dv1_div[k+1] <= dv1_div[k];
                dv1_r[k+1]   <= dv1_r[k];
                dv1_g[k+1]   <= dv1_g[k];
                dv1_b[k+1]   <= dv1_b[k];
                dv1_m[k+1]   <= dv1_m[k];
                dv1_big[k+1] <= dv1_big[k];
                dv1_hr[k+1]  <= dv1_hr[k];
            end
        end
    end

    // stage 3: mapped peak and channel products
    logic [HW-1:0] mapped;

    assign mapped = dv1_hr[HW] ? (htm_pkg::FX_ONE + dv1_q[HW]) : htm_pkg::FX_ONE;

    logic          dv2_v   [0:W];
    logic [PW-1:0] dv2_rem [0:W][3];
    logic [W-1:0]  dv2_q   [0:W][3];
    logic [W-1:0]  dv2_org [0:W][3];
    logic [W-1:0]  dv2_m   [0:W];
    logic          dv2_big [0:W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv2_v[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv2_v[0] <= dv1_v[HW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv2_rem[0][0] <= PW'(dv1_r[HW]) * PW'(mapped);
            dv2_rem[0][1] <= PW'(dv1_g[HW]) * PW'(mapped);
            dv2_rem[0][2] <= PW'(dv1_b[HW]) * PW'(mapped);
            dv2_org[0][0] <= dv1_r[HW];
            dv2_org[0][1] <= dv1_g[HW];
            dv2_org[0][2] <= dv1_b[HW];
            for (int c = 0; c < 3; c++)
            begin
                dv2_q[0][c] <= '0;
            end
            dv2_m[0]   <= dv1_m[HW];
            dv2_big[0] <= dv1_big[HW];
        end
    end

    // scale by mapped/peak, one quotient bit per stage for each channel
    for (genvar k = 0; k < W; k++)
    begin : g_div2
        logic [C2W-1:0] trial;
        logic [2:0]     fits;

        assign trial = C2W'(dv2_m[k]) << (W - 1 - k);
        for (genvar c = 0; c < 3; c++)
        begin : g_ch
            assign fits[c] = C2W'(dv2_rem[k][c]) >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv2_v[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv2_v[k+1] <= dv2_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    dv2_rem[k+1][c] <= fits[c] ? PW'(C2W'(dv2_rem[k][c]) - trial)
                                               : dv2_rem[k][c];
                    dv2_q[k+1][c]   <= dv2_q[k][c] | (fits[c] ? (W'(1) << (W - 1 - k)) : '0);
                    dv2_org[k+1][c] <= dv2_org[k][c];
                end
                dv2_m[k+1]   <= dv2_m[k];
                dv2_big[k+1] <= dv2_big[k];
            end
        end
    end

    // output register: pass small pixels through unchanged
    logic [W-1:0] red_reg, green_reg, blue_reg;
    logic         compressed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv2_v[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_reg        <= dv2_big[W] ? dv2_q[W][0] : dv2_org[W][0];
            green_reg      <= dv2_big[W] ? dv2_q[W][1] : dv2_org[W][1];
            blue_reg       <= dv2_big[W] ? dv2_q[W][2] : dv2_org[W][2];
            compressed_reg <= dv2_big[W];
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.red_out    = red_reg;
    assign result.green_out  = green_reg;
    assign result.blue_out   = blue_reg;
    assign result.compressed = compressed_reg;

    a_mapped_below_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (dv1_v[HW] && dv1_big[HW]) |-> ({{W{1'b0}}, mapped} < {{HW{1'b0}}, dv1_m[HW]}))
        else $error("mapped peak not below input peak");

    a_scale_never_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (dv2_v[W] && dv2_big[W]) |-> (dv2_q[W][0] <= dv2_org[W][0] &&
                                      dv2_q[W][1] <= dv2_org[W][1] &&
                                      dv2_q[W][2] <= dv2_org[W][2]))
        else $error("scaled channel exceeds its input");

    a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(dv2_v[W]) && $stable(dv1_v[HW]) && $stable(v1_reg)))
        else $error("pipeline moved during output stall");

endmodule

>>> tb/sv/hdr_highlight_tone_map_tb.sv
module hdr_highlight_tone_map_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 16;
    localparam int LATENCY = CW + 20;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [CW-1:0] red;
        logic [CW-1:0] green;
        logic [CW-1:0] blue;
        logic          compressed;
    } mapped_pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic headroom_we = 1'b0;
    logic [htm_pkg::HR_W-1:0] headroom_data = '0;

    htm_pixel_if #(.CHANNEL_WIDTH(CW)) pixel ();
    htm_result_if #(.CHANNEL_WIDTH(CW)) result ();

    hdr_highlight_tone_map #(.CHANNEL_WIDTH(CW)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .headroom_we(headroom_we),
        .headroom_data(headroom_data),
        .pixel(pixel.sink),
        .result(result.source)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    logic [htm_pkg::HR_W-1:0] tm_headroom = htm_pkg::HEADROOM_RESET;
    mapped_pixel_t   pending_pixels[$];
    int              mismatch_count = 0;
    longint          cycle_count = 0;
    bit              idle_enable = 1'b1;
    bit              hold_req = 1'b0;
    bit              hold_seen = 1'b0;
    int              sink_hold = 0;

    function automatic mapped_pixel_t tone_map(logic [CW-1:0] r, logic [CW-1:0] g,
                                               logic [CW-1:0] b);
        mapped_pixel_t o;
        logic [63:0] peak;
        logic [63:0] mapped;
        logic [63:0] span;
        logic [63:0] over;
        peak = r;
        if (g > peak) peak = g;
        if (b > peak) peak = b;
        if (peak <= htm_pkg::FX_ONE)
        begin
            o.red = r;
            o.green = g;
            o.blue = b;
            o.compressed = 1'b0;
            return o;
        end
        if (tm_headroom <= htm_pkg::FX_ONE)
            mapped = htm_pkg::FX_ONE;
        else
        begin
            span = tm_headroom - htm_pkg::FX_ONE;
            over = peak - htm_pkg::FX_ONE;
            mapped = htm_pkg::FX_ONE + (span * over) / (span + over);
        end
        o.red = CW'((64'(r) * mapped) / peak);
        o.green = CW'((64'(g) * mapped) / peak);
        o.blue = CW'((64'(b) * mapped) / peak);
        o.compressed = 1'b1;
        return o;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Sink side: random backpressure plus an optional long hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            sink_hold <= 299;
            result.ready <= 1'b0;
        end
        else if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            result.ready <= 1'b0;
        end
        else
            result.ready <= idle_enable ? ($urandom_range(99) >= 34) : 1'b1;
    end

    always @(posedge clk)
    begin
        mapped_pixel_t got;
        mapped_pixel_t want;
        if (rst_n && result.valid && result.ready)
        begin
            got = '{result.red_out, result.green_out, result.blue_out, result.compressed};
            if (pending_pixels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transfer %h", got);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected r=%h g=%h b=%h c=%b, got r=%h g=%h b=%h c=%b",
                                 want.red, want.green, want.blue, want.compressed,
                                 got.red, got.green, got.blue, got.compressed);
                end
            end
        end
    end

    task automatic send_pixel(logic [CW-1:0] r, logic [CW-1:0] g, logic [CW-1:0] b);
        if (idle_enable)
            while ($urandom_range(99) < 34)
            begin
                pixel.valid <= 1'b0;
                @(posedge clk);
            end
        pixel.valid <= 1'b1;
        pixel.red_in <= r;
        pixel.green_in <= g;
        pixel.blue_in <= b;
        @(posedge clk);
        while (!pixel.ready)
            @(posedge clk);
        pending_pixels.push_back(tone_map(r, g, b));
    endtask

    task automatic drain;
        pixel.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_headroom(logic [htm_pkg::HR_W-1:0] value);
        drain();
        headroom_we <= 1'b1;
        headroom_data <= value;
        @(posedge clk);
        headroom_we <= 1'b0;
        tm_headroom = value;
        @(posedge clk);
    endtask

    function automatic logic [CW-1:0] rand_channel();
        case ($urandom_range(3))
            0: return CW'($urandom_range(1024));
            1: return CW'($urandom_range(1025, 4096));
            2: return CW'($urandom_range(65535));
            default: return CW'($urandom_range(1023, 1026));
        endcase
    endfunction

    task automatic test_directed;
        logic [htm_pkg::HR_W-1:0] rooms[4] = '{htm_pkg::HEADROOM_RESET, 16'd0, 16'd4096,
                                               16'hFFFF};
        foreach (rooms[i])
        begin
            if (i != 0)
                write_headroom(rooms[i]);
            send_pixel(16'd0, 16'd0, 16'd0);
            send_pixel(16'd1024, 16'd1024, 16'd1024);
            send_pixel(16'd1025, 16'd0, 16'd512);
            send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
            send_pixel(16'd0, 16'hFFFF, 16'd1);
            send_pixel(16'h5555, 16'hAAAA, 16'd2048);
        end
    endtask

    task automatic test_random(int count, logic [htm_pkg::HR_W-1:0] room);
        write_headroom(room);
        repeat (count) send_pixel(rand_channel(), rand_channel(), rand_channel());
    endtask

    task automatic test_backpressure;
        write_headroom(16'd2048);
        // start a long hold-off in the sink process
        hold_req = !hold_req;
        repeat (100) send_pixel(rand_channel(), rand_channel(), rand_channel());
        drain();
    endtask

    task automatic test_no_idle;
        idle_enable = 1'b0;
        test_random(300, htm_pkg::HR_W'($urandom_range(65535)));
        idle_enable = 1'b1;
    endtask

    initial
    begin
        pixel.valid <= 1'b0;
        pixel.red_in <= '0;
        pixel.green_in <= '0;
        pixel.blue_in <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(400, 16'd1024);
        test_random(400, 16'hFFFF);
        test_random(300, htm_pkg::HR_W'($urandom_range(1025, 8192)));
        test_backpressure();
        test_no_idle();
        test_random(400, 16'd1);
        drain();
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
